@@ sv/swle_pkg.sv @@
package swle_pkg;

    localparam logic [7:0] CMD_BYTE   = 8'b0011_1010;
    localparam int         FRAME_BITS = 32;
    localparam int         CNT_W      = 16;
    localparam int         BITS_W     = 6;

    localparam logic [BITS_W-1:0] FRAME_BITS_CNT = BITS_W'(FRAME_BITS);

    localparam logic [CNT_W-1:0] ONE_PAD_RST  = 16'd4;
    localparam logic [CNT_W-1:0] ZERO_PAD_RST = 16'd6;
    localparam logic [CNT_W-1:0] END_GAP_RST  = 16'd16;
    localparam logic [CNT_W-1:0] LATCH_GAP_RST = 16'd64;

    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_BIT_PAD  = 8'd0,
        CFG_ZERO_BIT_PAD = 8'd1,
        CFG_END_GAP      = 8'd2,
        CFG_LATCH_GAP    = 8'd3
    } t_cfg_idx;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b000_0001,
        PH_HI1   = 7'b000_0010,
        PH_LO1   = 7'b000_0100,
        PH_HI2   = 7'b000_1000,
        PH_LO2   = 7'b001_0000,
        PH_PAD   = 7'b010_0000,
        PH_TRAIL = 7'b100_0000
    } t_phase;

    typedef struct packed {
        logic [CNT_W-1:0] one_bit_pad;
        logic [CNT_W-1:0] zero_bit_pad;
        logic [CNT_W-1:0] end_gap;
        logic [CNT_W-1:0] latch_gap;
    } t_cfg;

    typedef struct packed {
        logic       command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       latch;
    } t_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_result;

endpackage

@@ sv/swle_core.sv @@
module swle_core
    import swle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase                  r_phase, n_phase;
    logic [FRAME_BITS-1:0]   r_shift, n_shift;
    logic [BITS_W-1:0]       r_bits, n_bits;
    logic [CNT_W-1:0]        r_gap, n_gap;
    logic                    r_latch, n_latch;

    logic                    phase_known;
    t_phase                  ph;
    logic [FRAME_BITS-1:0]   ld_shift;
    logic [BITS_W-1:0]       ld_bits;
    logic                    ld_latch;
    logic [FRAME_BITS-1:0]   be_shift;
    logic [BITS_W-1:0]       be_bits;
    logic [CNT_W-1:0]        be_gap;
    logic [CNT_W-1:0]        be_gap_cnt;
    t_phase                  be_phase;
    logic                    be_done;
    logic [CNT_W-1:0]        pad_sel;
    logic                    level;
    logic                    done;
    logic                    rej;

    assign phase_known = (r_phase == PH_HI1) || (r_phase == PH_LO1) || (r_phase == PH_HI2)
                      || (r_phase == PH_LO2) || (r_phase == PH_PAD) || (r_phase == PH_TRAIL);

    always_comb begin
        ph       = phase_known ? r_phase : PH_IDLE;
        ld_shift = r_shift;
        ld_bits  = r_bits;
        ld_latch = r_latch;
        rej      = 1'b0;
        if (i_item.command) begin
            if (ph == PH_IDLE) begin
                ld_shift = {CMD_BYTE, i_item.red, i_item.green, i_item.blue};
                ld_bits  = FRAME_BITS_CNT;
                ld_latch = i_item.latch;
                ph       = PH_HI1;
            end else begin
                rej = 1'b1;
            end
        end
    end

    always_comb begin
        be_shift   = {ld_shift[FRAME_BITS-2:0], 1'b0};
        be_gap_cnt = ld_latch ? i_cfg.latch_gap : i_cfg.end_gap;
        be_done    = 1'b0;
        be_gap     = r_gap;
        if (ld_bits <= BITS_W'(1)) begin
            be_bits = '0;
            if (be_gap_cnt == '0) begin
                be_done  = 1'b1;
                be_phase = PH_IDLE;
            end else begin
                be_gap   = be_gap_cnt;
                be_phase = PH_TRAIL;
            end
        end else begin
            be_bits  = ld_bits - BITS_W'(1);
            be_phase = PH_HI1;
        end
    end

    always_comb begin
        n_shift = ld_shift;
        n_bits  = ld_bits;
        n_latch = ld_latch;
        n_gap   = r_gap;
        n_phase = ph;
        level   = 1'b0;
        done    = 1'b0;
        pad_sel = (ph == PH_LO2) ? i_cfg.one_bit_pad : i_cfg.zero_bit_pad;
        case (ph)
            PH_HI1: begin
                level   = 1'b1;
                n_phase = PH_LO1;
            end
            PH_HI2: begin
                level   = 1'b1;
                n_phase = PH_LO2;
            end
            PH_LO1, PH_LO2: begin
                if (ph == PH_LO1 && ld_shift[FRAME_BITS-1]) begin
                    n_phase = PH_HI2;
                end else if (pad_sel == '0) begin
                    n_shift = be_shift;
                    n_bits  = be_bits;
                    n_gap   = be_gap;
                    n_phase = be_phase;
                    done    = be_done;
                end else begin
                    n_gap   = pad_sel;
                    n_phase = PH_PAD;
                end
            end
            PH_PAD: begin
                if (r_gap <= CNT_W'(1)) begin
                    n_shift = be_shift;
                    n_bits  = be_bits;
                    n_gap   = (be_phase == PH_TRAIL) ? be_gap : '0;
                    n_phase = be_phase;
                    done    = be_done;
                end else begin
                    n_gap = r_gap - CNT_W'(1);
                end
            end
            PH_TRAIL: begin
                if (r_gap <= CNT_W'(1)) begin
                    n_gap   = '0;
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_gap = r_gap - CNT_W'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_result.line_level = level;
    assign o_result.busy_res   = (ph != PH_IDLE);
    assign o_result.frame_done = done;
    assign o_result.rejected   = rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_shift <= '0;
            r_bits  <= '0;
            r_gap   <= '0;
            r_latch <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_gap   <= n_gap;
            r_latch <= n_latch;
        end
    end

endmodule

@@ sv/single_wire_led_frame_encoder.sv @@
// Single-wire LED frame encoder.
// Each beat on the slave stream is one tick of line timing. A beat with
// tuser (command) set starts a frame when the encoder is idle: command byte
// 0x3A, then red, green and blue, MSB first. A send while a frame or its
// trailing gap runs is dropped and flagged as rejected in the result.
// Every accepted beat yields exactly one master beat carrying the line level
// and busy flag in tdata, frame done in tlast and rejected in tuser.
// Each accepted beat's result appears in the cycle after; one beat is taken
// every cycle unless the receiver stalls, and each one steps the sequencer.
// The result sits in an output register, so s_axis_tready stays high while
// the master side takes the result or the register is empty. When the
// receiver stalls, the result is held and no further beat is taken, so line
// time only advances with accepted beats.
// Configuration writes (index 0 one bit pad, 1 zero bit pad, 2 end gap,
// 3 latch gap) are always ready; other indexes are ignored.
// Synchronous active-low reset returns the sequencer to idle, empties the
// output register and restores the default pad and gap counts.
module single_wire_led_frame_encoder
    import swle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], latch[24]
    input  logic                 s_axis_tuser,   // command[0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // line_level[0], busy_res[1]
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser,   // rejected[0]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    t_cfg    r_cfg;
    t_item   item;
    t_result result;
    t_result r_result;
    logic    r_m_valid;
    logic    s_fire;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign item.command = s_axis_tuser;
    assign item.red     = s_axis_tdata[7:0];
    assign item.green   = s_axis_tdata[15:8];
    assign item.blue    = s_axis_tdata[23:16];
    assign item.latch   = s_axis_tdata[24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_bit_pad  <= ONE_PAD_RST;
            r_cfg.zero_bit_pad <= ZERO_PAD_RST;
            r_cfg.end_gap      <= END_GAP_RST;
            r_cfg.latch_gap    <= LATCH_GAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ONE_BIT_PAD:  r_cfg.one_bit_pad  <= i_cfg_data;
                CFG_ZERO_BIT_PAD: r_cfg.zero_bit_pad <= i_cfg_data;
                CFG_END_GAP:      r_cfg.end_gap      <= i_cfg_data;
                CFG_LATCH_GAP:    r_cfg.latch_gap    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    swle_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_fire),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_result.busy_res, r_result.line_level};
    assign m_axis_tlast  = r_result.frame_done;
    assign m_axis_tuser  = r_result.rejected;

endmodule

@@ sv/swle_checker.sv @@
module swle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_high_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[0] || m_axis_tlast || m_axis_tuser) |-> m_axis_tdata[1])
        else $error("line high, frame done or reject reported while not busy");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output register is empty");

    a_result_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat produced no result beat");

endmodule

bind single_wire_led_frame_encoder swle_checker u_swle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import swle_pkg::*;

    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_PHASES   = 4;
    localparam int TICKS_PER_PHASE = 50;

    typedef struct packed {
        logic [31:0]       shift;
        logic [BITS_W-1:0] bits_left;
        t_phase            phase;
        logic [CNT_W-1:0]  gap;
        logic              latch_pending;
    } t_enc_state;

    class LineScoreboard;
        t_enc_state st;
        t_cfg       cfg;
        t_result    line_expect[$];
        logic       done_now;
        int         errors;
        int         ticks;
        int         frames;
        int         refusals;
        int         completions;

        function new();
            st = '0;
            st.phase = PH_IDLE;
            cfg.one_bit_pad = ONE_PAD_RST;
            cfg.zero_bit_pad = ZERO_PAD_RST;
            cfg.end_gap = END_GAP_RST;
            cfg.latch_gap = LATCH_GAP_RST;
            errors = 0;
            ticks = 0;
            frames = 0;
            refusals = 0;
            completions = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CNT_W-1:0] value);
            case (idx)
                CFG_ONE_BIT_PAD: cfg.one_bit_pad = value;
                CFG_ZERO_BIT_PAD: cfg.zero_bit_pad = value;
                CFG_END_GAP: cfg.end_gap = value;
                CFG_LATCH_GAP: cfg.latch_gap = value;
                default: ;
            endcase
        endfunction

        function void end_bit();
            logic [CNT_W-1:0] trail;
            st.shift = st.shift << 1;
            if (st.bits_left <= 1) begin
                trail = st.latch_pending ? cfg.latch_gap : cfg.end_gap;
                st.bits_left = '0;
                if (trail == 0) begin
                    done_now = 1'b1;
                    st.phase = PH_IDLE;
                end else begin
                    st.gap = trail;
                    st.phase = PH_TRAIL;
                end
            end else begin
                st.bits_left = st.bits_left - 1'b1;
                st.phase = PH_HI1;
            end
        endfunction

        function void start_pad(logic [CNT_W-1:0] pad);
            if (pad == 0) begin
                end_bit();
            end else begin
                st.gap = pad;
                st.phase = PH_PAD;
            end
        endfunction

        function t_result advance(t_item it);
            t_result r;
            r = '0;
            done_now = 1'b0;
            if (it.command) begin
                if (st.phase == PH_IDLE) begin
                    st.shift = {CMD_BYTE, it.red, it.green, it.blue};
                    st.bits_left = FRAME_BITS_CNT;
                    st.latch_pending = it.latch;
                    st.phase = PH_HI1;
                end else begin
                    r.rejected = 1'b1;
                end
            end
            r.busy_res = (st.phase != PH_IDLE);
            case (st.phase)
                PH_HI1: begin
                    r.line_level = 1'b1;
                    st.phase = PH_LO1;
                end
                PH_LO1: begin
                    if (st.shift[31]) begin
                        st.phase = PH_HI2;
                    end else begin
                        start_pad(cfg.zero_bit_pad);
                    end
                end
                PH_HI2: begin
                    r.line_level = 1'b1;
                    st.phase = PH_LO2;
                end
                PH_LO2: begin
                    start_pad(cfg.one_bit_pad);
                end
                PH_PAD: begin
                    if (st.gap <= 1) begin
                        st.gap = '0;
                        end_bit();
                    end else begin
                        st.gap = st.gap - 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (st.gap <= 1) begin
                        st.gap = '0;
                        done_now = 1'b1;
                        st.phase = PH_IDLE;
                    end else begin
                        st.gap = st.gap - 1'b1;
                    end
                end
                default: ;
            endcase
            r.frame_done = done_now;
            return r;
        endfunction

        function t_result preview(t_item it);
            t_enc_state saved;
            t_result    r;
            saved = st;
            r = advance(it);
            st = saved;
            return r;
        endfunction

        function void note_beat(t_item it);
            t_result r;
            r = advance(it);
            line_expect.push_back(r);
            ticks++;
            if (it.command && !r.rejected) begin
                frames++;
            end
            refusals += r.rejected;
            completions += r.frame_done;
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (line_expect.size() == 0) begin
                $error("Result beat arrived with no tick waiting for it.");
                errors++;
                return;
            end
            want = line_expect.pop_front();
            if (got.line_level !== want.line_level) begin
                $error("line_level: expected %0b, got %0b", want.line_level, got.line_level);
                errors++;
            end
            if (got.busy_res !== want.busy_res) begin
                $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
                errors++;
            end
            if (got.frame_done !== want.frame_done) begin
                $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
                errors++;
            end
            if (got.rejected !== want.rejected) begin
                $error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CNT_W-1:0]     i_cfg_data;

    LineScoreboard sb;
    bit            jitter_on;
    int            settings_used;

    single_wire_led_frame_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_item any_item(input logic cmd);
        t_item it;
        it.command = cmd;
        it.red = 8'($urandom_range(0, 255));
        it.green = 8'($urandom_range(0, 255));
        it.blue = 8'($urandom_range(0, 255));
        it.latch = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_item frame_item(input logic [7:0] red, input logic [7:0] green,
                                         input logic [7:0] blue, input logic latch);
        t_item it;
        it.command = 1'b1;
        it.red = red;
        it.green = green;
        it.blue = blue;
        it.latch = latch;
        return it;
    endfunction

    task automatic send_tick(input t_item it);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = it.command;
        s_axis_tdata = {7'b0, it.latch, it.blue, it.green, it.red};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(it);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tuser = 1'($urandom_range(0, 1));
            s_axis_tdata = $urandom;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.line_expect.size() != 0) @(posedge i_clk);
    endtask

    task automatic finish_frame();
        while (sb.st.phase != PH_IDLE) send_tick(any_item(1'b0));
        drain_results();
    endtask

    // Runs the current frame down and places a send on its last tick.
    task automatic send_on_done();
        t_item   it;
        t_result peek;
        it = any_item(1'b0);
        peek = sb.preview(it);
        while (sb.st.phase != PH_IDLE && !peek.frame_done) begin
            send_tick(it);
            it = any_item(1'b0);
            peek = sb.preview(it);
        end
        it.command = 1'b1;
        send_tick(it);
    endtask

    task automatic load_setting(input t_cfg_idx idx, input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input logic [CNT_W-1:0] one_pad, input logic [CNT_W-1:0] zero_pad,
                                 input logic [CNT_W-1:0] end_gap, input logic [CNT_W-1:0] latch_gap);
        finish_frame();
        load_setting(CFG_ONE_BIT_PAD, one_pad);
        load_setting(CFG_ZERO_BIT_PAD, zero_pad);
        load_setting(CFG_END_GAP, end_gap);
        load_setting(CFG_LATCH_GAP, latch_gap);
        settings_used++;
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (jitter_on) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_beat('{line_level: m_axis_tdata[0], busy_res: m_axis_tdata[1],
                            frame_done: m_axis_tlast, rejected: m_axis_tuser});
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_item it;
        logic  cmd;
        sb = new();
        jitter_on = 1'b0;
        settings_used = 1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default timing: a refused send mid-frame, then one on the last tick.
        send_tick(any_item(1'b0));
        send_tick(frame_item(8'hFF, 8'h00, 8'hFF, 1'b0));
        repeat (10) send_tick(any_item(1'b0));
        send_tick(any_item(1'b1));
        send_on_done();
        send_tick(frame_item(8'h00, 8'hFF, 8'h00, 1'b1));
        send_on_done();

        // No pads and no trailing gap: done lands on the last bit tick.
        apply_setting('0, '0, '0, '0);
        send_tick(frame_item(8'hA5, 8'h5A, 8'hC3, 1'b1));
        send_on_done();
        send_tick(frame_item(8'h3C, 8'h0F, 8'hF0, 1'b0));
        send_on_done();
        send_tick(frame_item(8'h00, 8'h00, 8'h00, 1'b0));

        // Longer pads and gaps, each used by only a few bits of one frame.
        apply_setting(16'd12, '0, '0, 16'd48);
        send_tick(frame_item(8'h00, 8'h00, 8'h00, 1'b1));
        apply_setting('0, 16'd12, 16'd48, '0);
        send_tick(frame_item(8'hFF, 8'hFF, 8'hFF, 1'b0));
        finish_frame();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1) begin
                apply_setting(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                              16'($urandom_range(0, 120)), 16'($urandom_range(0, 120)));
            end else begin
                apply_setting(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                              16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
            end
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if (n % 50 == 0) jitter_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 199) == 0) drain_results();
                if (jitter_on) pause_sender(pick_gap());
                if (sb.st.phase == PH_IDLE) begin
                    cmd = ($urandom_range(0, 9) < 4);
                end else begin
                    cmd = ($urandom_range(0, 39) == 0);
                end
                it = any_item(cmd);
                send_tick(it);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("Run drove %0d line ticks: %0d frames started, %0d completed, %0d sends refused.",
                 sb.ticks, sb.frames, sb.completions, sb.refusals);
        $display("Timing settings exercised: %0d, from all-zero pads and gaps up to 120 ticks.",
                 settings_used);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
